// File: rtl/adsr_pkg.sv
// Shared types, constants and widths for the ADSR envelope generator.
package adsr_pkg;

    localparam int SAMPLES_PER_MS = 48;
    localparam int MAX_MS         = 10000;
    localparam int FULL_SCALE     = 32768;

    localparam int MS_W    = 14;
    localparam int LVL_W   = 16;
    localparam int STEP_W  = 21;
    localparam int PH_W    = 3;
    localparam int CFG_W   = 16;
    localparam int CFGI_W  = 2;
    localparam int LEN_W   = $clog2(MAX_MS * SAMPLES_PER_MS + 1);
    localparam int SQ_W    = 2 * LEN_W;
    localparam int MUL_W   = LEN_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int PART_W  = LVL_W + LEN_W;
    localparam int NUM_W   = LVL_W + SQ_W;
    localparam int QUO_W   = LVL_W;
    localparam int DCNT_W  = $clog2(QUO_W);

    localparam logic [CFGI_W-1:0] CFG_ATTACK  = CFGI_W'(0);
    localparam logic [CFGI_W-1:0] CFG_DECAY   = CFGI_W'(1);
    localparam logic [CFGI_W-1:0] CFG_SUSTAIN = CFGI_W'(2);
    localparam logic [CFGI_W-1:0] CFG_RELEASE = CFGI_W'(3);

    typedef enum logic [PH_W-1:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_SQ,
        OP_PROD,
        OP_FORMX,
        OP_MLO,
        OP_MHI,
        OP_ACC,
        OP_DIV,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SQ,
        S_PROD,
        S_FORMX,
        S_MLO,
        S_MHI,
        S_ACC,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } dp_sts_t;

endpackage

// File: rtl/adsr_ctrl.sv
// Sequencer for the ADSR envelope generator: one sample transfer at a time.
module adsr_ctrl
    import adsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t              state_reg;
    state_t              state_next;
    logic [DCNT_W-1:0]   div_cnt_reg;
    logic [DCNT_W-1:0]   div_cnt_next;
    logic                div_last;

    assign div_last = (div_cnt_reg == DCNT_W'(QUO_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_PREP;
            S_PREP:  state_next = sts.need_div ? S_SQ : S_FIN;
            S_SQ:    state_next = S_PROD;
            S_PROD:  state_next = S_FORMX;
            S_FORMX: state_next = S_MLO;
            S_MLO:   state_next = S_MHI;
            S_MHI:   state_next = S_ACC;
            S_ACC:   state_next = S_DIV;
            S_DIV:   if (div_last) state_next = S_FIN;
            S_FIN:   if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op       = OP_NONE;
        in_stall     = 1'b1;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid) cmd.op = OP_LOAD;
            end
            S_PREP:  cmd.op = OP_PREP;
            S_SQ:    cmd.op = OP_SQ;
            S_PROD:  cmd.op = OP_PROD;
            S_FORMX: cmd.op = OP_FORMX;
            S_MLO:   cmd.op = OP_MLO;
            S_MHI:   cmd.op = OP_MHI;
            S_ACC:
            begin
                cmd.op       = OP_ACC;
                div_cnt_next = '0;
            end
            S_DIV:
            begin
                cmd.op       = OP_DIV;
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            S_FIN:   if (sts.out_free) cmd.op = OP_FINISH;
            default: cmd.op = OP_NONE;
        endcase
    end

`ifndef SYNTH
    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_PREP))
        else $error("accepted transfer did not start evaluation");

    a_div_count_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |=> (div_cnt_reg == '0))
        else $error("divider count not cleared on entry");
`endif

endmodule

// File: rtl/adsr_dp.sv
// Datapath of the ADSR envelope generator: state, shared multiplier, divider.
module adsr_dp
    import adsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    input  logic              cfg_we,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              gate,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [LVL_W-1:0]  level,
    output logic [PH_W-1:0]   phase
);

    logic [MS_W-1:0]   attack_ms_reg;
    logic [MS_W-1:0]   decay_ms_reg;
    logic [LVL_W-1:0]  sustain_reg;
    logic [MS_W-1:0]   release_ms_reg;

    phase_t            phase_reg;
    logic [STEP_W-1:0] step_reg;
    logic [LVL_W-1:0]  rel_start_reg;
    logic [LVL_W-1:0]  last_level_reg;
    logic              out_valid_reg;

    logic              gate_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  n_reg;
    phase_t            divph_reg;
    logic              div_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_W-1:0]   prod_reg;
    logic [SQ_W-1:0]   x_reg;
    logic [PART_W-1:0] plo_reg;
    logic [PART_W-1:0] phi_reg;
    logic [SQ_W:0]     numlo_reg;
    logic [SQ_W-1:0]   rem_reg;
    logic [QUO_W-1:0]  shl_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [LVL_W-1:0]  level_reg;
    logic [PH_W-1:0]   phase_out_reg;

    phase_t            ph1;
    phase_t            phase_next;
    logic [STEP_W-1:0] st1;
    logic [STEP_W-1:0] step_next;
    logic [LVL_W-1:0]  rel_start_next;
    logic [MS_W-1:0]   ms_sel;
    logic [MS_W-1:0]   ms_clamp;
    logic [LEN_W-1:0]  len_next;
    logic              at_end;
    logic              done;
    logic              div_next;
    logic [LVL_W-1:0]  lvl_next;
    logic [LVL_W-1:0]  sus_val;
    logic [LVL_W-1:0]  coef;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [SQ_W-1:0]   bias;
    logic [NUM_W-1:0]  num_full;
    logic [SQ_W:0]     trial;
    logic [SQ_W:0]     diff;
    logic              qbit;
    logic [LVL_W-1:0]  level_next;

    assign sus_val = (sustain_reg > LVL_W'(FULL_SCALE)) ? LVL_W'(FULL_SCALE) : sustain_reg;

    // gate edge handling, phase length and end-of-phase check
    always_comb
    begin
        ph1            = phase_reg;
        st1            = step_reg;
        rel_start_next = rel_start_reg;
        if (!gate_reg && (phase_reg == PH_ATTACK || phase_reg == PH_DECAY ||
                          phase_reg == PH_SUSTAIN))
        begin
            ph1            = PH_RELEASE;
            rel_start_next = last_level_reg;
            st1            = '0;
        end
        else if (gate_reg && (phase_reg == PH_IDLE || phase_reg == PH_RELEASE))
        begin
            ph1 = PH_ATTACK;
            st1 = '0;
        end

        case (ph1)
            PH_ATTACK: ms_sel = attack_ms_reg;
            PH_DECAY:  ms_sel = decay_ms_reg;
            default:   ms_sel = release_ms_reg;
        endcase
        ms_clamp = (ms_sel > MS_W'(MAX_MS)) ? MS_W'(MAX_MS) : ms_sel;
        len_next = LEN_W'(ms_clamp) * LEN_W'(SAMPLES_PER_MS);
        at_end   = (st1 >= STEP_W'(len_next));

        phase_next = ph1;
        lvl_next   = '0;
        div_next   = 1'b0;
        done       = 1'b0;
        case (ph1)
            PH_ATTACK:
            begin
                if (at_end)
                begin
                    lvl_next   = LVL_W'(FULL_SCALE);
                    phase_next = PH_DECAY;
                    done       = 1'b1;
                end
                else
                    div_next = 1'b1;
            end
            PH_DECAY:
            begin
                if (at_end)
                begin
                    lvl_next   = sus_val;
                    phase_next = PH_SUSTAIN;
                    done       = 1'b1;
                end
                else
                    div_next = 1'b1;
            end
            PH_SUSTAIN: lvl_next = sus_val;
            PH_RELEASE:
            begin
                if (at_end)
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                else
                    div_next = 1'b1;
            end
            default: phase_next = PH_IDLE;
        endcase

        if (done || phase_next == PH_IDLE || phase_next == PH_SUSTAIN)
            step_next = '0;
        else
            step_next = st1 + 1'b1;
    end

    always_comb
    begin
        case (divph_reg)
            PH_ATTACK: coef = LVL_W'(FULL_SCALE);
            PH_DECAY:  coef = LVL_W'(FULL_SCALE) - sus_val;
            default:   coef = rel_start_reg;
        endcase
    end

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ:
            begin
                mul_a = MUL_W'(len_reg);
                mul_b = MUL_W'(len_reg);
            end
            OP_PROD:
            begin
                mul_a = MUL_W'(n_reg);
                if (divph_reg == PH_ATTACK)
                    mul_b = (MUL_W'(len_reg) << 1) - MUL_W'(n_reg);
                else
                    mul_b = MUL_W'(n_reg);
            end
            OP_MLO:
            begin
                mul_a = MUL_W'(coef);
                mul_b = MUL_W'(x_reg[LEN_W-1:0]);
            end
            OP_MHI:
            begin
                mul_a = MUL_W'(coef);
                mul_b = MUL_W'(x_reg[SQ_W-1:LEN_W]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign bias     = (divph_reg == PH_DECAY) ? (sq_reg - 1'b1) : '0;
    assign num_full = NUM_W'({phi_reg, {LEN_W{1'b0}}}) + NUM_W'(numlo_reg);

    // restoring divide, one quotient bit per cycle
    assign trial = {rem_reg, shl_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, sq_reg};
    assign qbit  = (trial >= {1'b0, sq_reg});

    always_comb
    begin
        if (!div_reg)
            level_next = lvl_reg;
        else if (divph_reg == PH_DECAY)
            level_next = LVL_W'(FULL_SCALE) - quo_reg;
        else
            level_next = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_ms_reg  <= MS_W'(10);
            decay_ms_reg   <= MS_W'(100);
            sustain_reg    <= LVL_W'(16384);
            release_ms_reg <= MS_W'(200);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ATTACK:  attack_ms_reg  <= cfg_data[MS_W-1:0];
                CFG_DECAY:   decay_ms_reg   <= cfg_data[MS_W-1:0];
                CFG_SUSTAIN: sustain_reg    <= cfg_data[LVL_W-1:0];
                CFG_RELEASE: release_ms_reg <= cfg_data[MS_W-1:0];
                default:     attack_ms_reg  <= attack_ms_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            step_reg       <= '0;
            rel_start_reg  <= '0;
            last_level_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_PREP)
            begin
                phase_reg     <= phase_next;
                step_reg      <= step_next;
                rel_start_reg <= rel_start_next;
            end
            if (cmd.op == OP_FINISH)
            begin
                last_level_reg <= level_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD: gate_reg <= gate;
            OP_PREP:
            begin
                len_reg   <= len_next;
                n_reg     <= st1[LEN_W-1:0];
                divph_reg <= ph1;
                div_reg   <= div_next;
                lvl_reg   <= lvl_next;
            end
            OP_SQ:    sq_reg   <= mul_p[SQ_W-1:0];
            OP_PROD:  prod_reg <= mul_p[SQ_W-1:0];
            OP_FORMX: x_reg    <= (divph_reg == PH_RELEASE) ? (sq_reg - prod_reg) : prod_reg;
            OP_MLO:   plo_reg  <= mul_p[PART_W-1:0];
            OP_MHI:
            begin
                phi_reg   <= mul_p[PART_W-1:0];
                numlo_reg <= (SQ_W+1)'(plo_reg) + (SQ_W+1)'(bias);
            end
            OP_ACC:
            begin
                rem_reg <= num_full[NUM_W-1:QUO_W];
                shl_reg <= num_full[QUO_W-1:0];
            end
            OP_DIV:
            begin
                rem_reg <= qbit ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
                shl_reg <= {shl_reg[QUO_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], qbit};
            end
            OP_FINISH:
            begin
                level_reg     <= level_next;
                phase_out_reg <= phase_reg;
            end
            default: gate_reg <= gate_reg;
        endcase
    end

    assign sts.need_div = div_next;
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign level        = level_reg;
    assign phase        = phase_out_reg;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIV) |-> (rem_reg < sq_reg))
        else $error("divider remainder not below divisor");

    a_step_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SQ) |-> (n_reg < len_reg))
        else $error("curve evaluated past phase end");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (level_reg <= LVL_W'(FULL_SCALE)))
        else $error("level above full scale");
`endif

endmodule

// File: rtl/adsr_envelope_generator_core.sv
// Top level of the ADSR envelope generator: sequencer plus datapath.
//
//  channel   signals                           transfer when
//  in        in_valid, in_stall, gate           in_valid && !in_stall
//  out       out_valid, out_stall, level, phase out_valid && !out_stall
//  cfg       cfg_we, cfg_index, cfg_data        cfg_we
//
// A sample needs no curve point in idle, in sustain or at a phase end; any
// other sample is evaluated in six steps around one shared 20x20 multiplier
// (four products), then 16 restoring divide steps. Reset clears phase, step
// count, stored levels and the output valid flag, and loads the register
// defaults. A stalled output holds the sequencer in its last state; the next
// sample is taken as soon as the result is registered.
module adsr_envelope_generator_core
    import adsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              gate,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [LVL_W-1:0]  level,
    output logic [PH_W-1:0]   phase,
    input  logic              cfg_we,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    adsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    adsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gate      (gate),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .level     (level),
        .phase     (phase)
    );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the ADSR envelope generator core.
module tb_top
    import adsr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CFGI_W-1:0] idx;
        logic [CFG_W-1:0]  data;
        bit                g;
        bit                fixed;
        logic [LVL_W-1:0]  lvl;
        phase_t            ph;
    } stim_row_t;

    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        phase_t           ph;
    } env_sample_t;

    localparam int DIR_ROWS = 31;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b0, 1'b1, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b1, 1'b1, 16'd0,     PH_ATTACK},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b0, 1'b1, 16'd0,     PH_RELEASE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b0, 1'b1, 16'd0,     PH_RELEASE},
        '{ROW_WRITE, CFG_ATTACK,  16'd0,     1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_WRITE, CFG_DECAY,   16'd0,     1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_WRITE, CFG_SUSTAIN, 16'hFFFF,  1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_WRITE, CFG_RELEASE, 16'd0,     1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b1, 1'b1, 16'd32768, PH_DECAY},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b1, 1'b1, 16'd32768, PH_SUSTAIN},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b1, 1'b1, 16'd32768, PH_SUSTAIN},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b0, 1'b1, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b0, 1'b1, 16'd0,     PH_IDLE},
        '{ROW_WRITE, CFG_ATTACK,  16'h3FFF,  1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_WRITE, CFG_DECAY,   16'd1,     1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_WRITE, CFG_SUSTAIN, 16'd0,     1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_WRITE, CFG_RELEASE, 16'd16383, 1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b1, 1'b1, 16'd0,     PH_ATTACK},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b1, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b1, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b1, 1'b1, 16'd0,     PH_ATTACK},
        '{ROW_WRITE, CFG_ATTACK,  16'd0,     1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_WRITE, CFG_SUSTAIN, 16'd32768, 1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b1, 1'b1, 16'd32768, PH_DECAY},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b1, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_WRITE, CFG_RELEASE, 16'd0,     1'b0, 1'b0, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b0, 1'b1, 16'd0,     PH_IDLE},
        '{ROW_TICK,  CFG_ATTACK,  16'd0,     1'b0, 1'b1, 16'd0,     PH_IDLE}
    };

    localparam int SETTINGS_RUN   = 10;
    localparam int TICKS_PER_SET  = 125;
    localparam int QUIET_FROM     = 700;
    localparam int QUIET_TO       = 900;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_CYCLES    = 250;
    localparam int SETTLE_CYCLES  = 30;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              gate;
    logic              out_valid;
    logic              out_stall;
    logic [LVL_W-1:0]  level;
    logic [PH_W-1:0]   phase;
    logic              cfg_we;
    logic [CFGI_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    logic [MS_W-1:0]   atk_cfg;
    logic [MS_W-1:0]   dec_cfg;
    logic [LVL_W-1:0]  sus_cfg;
    logic [MS_W-1:0]   rel_cfg;
    phase_t            env_phase;
    logic [STEP_W-1:0] env_step;
    logic [LVL_W-1:0]  rel_start;
    logic [LVL_W-1:0]  prev_level;

    env_sample_t envelope_due[$];
    int          ticks_sent;
    int          results_seen;
    int          mismatches;
    int          hold_left;
    bit          hold_done;

    adsr_envelope_generator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .gate      (gate),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (level),
        .phase     (phase),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic longint unsigned seg_samples(logic [MS_W-1:0] ms);
        longint unsigned m;
        m = (ms > MAX_MS) ? MAX_MS : ms;
        return m * SAMPLES_PER_MS;
    endfunction

    function automatic env_sample_t next_envelope(bit g);
        longint unsigned n, len, sq, nn, sus, lvl;
        bit              done;
        env_sample_t     r;
        done = 1'b0;
        lvl  = 0;
        sq   = 0;
        sus  = (sus_cfg > FULL_SCALE) ? FULL_SCALE : sus_cfg;
        if (!g && (env_phase == PH_ATTACK || env_phase == PH_DECAY ||
                   env_phase == PH_SUSTAIN)) begin
            env_phase = PH_RELEASE;
            rel_start = prev_level;
            env_step  = '0;
        end
        else if (g && (env_phase == PH_IDLE || env_phase == PH_RELEASE)) begin
            env_phase = PH_ATTACK;
            env_step  = '0;
        end
        n = env_step;
        case (env_phase)
            PH_ATTACK:
            begin
                len = seg_samples(atk_cfg);
                if (n >= len) begin
                    lvl       = FULL_SCALE;
                    env_phase = PH_DECAY;
                    done      = 1'b1;
                end
                else begin
                    sq  = len * len;
                    lvl = (64'(FULL_SCALE) * n * (2 * len - n)) / sq;
                end
            end
            PH_DECAY:
            begin
                len = seg_samples(dec_cfg);
                if (n >= len) begin
                    lvl       = sus;
                    env_phase = PH_SUSTAIN;
                    done      = 1'b1;
                end
                else begin
                    sq  = len * len;
                    nn  = (FULL_SCALE - sus) * n * n;
                    lvl = FULL_SCALE - (nn + sq - 1) / sq;
                end
            end
            PH_SUSTAIN:
            begin
                lvl = sus;
            end
            PH_RELEASE:
            begin
                len = seg_samples(rel_cfg);
                if (n >= len) begin
                    lvl       = 0;
                    env_phase = PH_IDLE;
                    done      = 1'b1;
                end
                else begin
                    sq  = len * len;
                    lvl = (64'(rel_start) * (sq - n * n)) / sq;
                end
            end
            default:
            begin
                env_phase = PH_IDLE;
                lvl       = 0;
            end
        endcase
        if (done || env_phase == PH_IDLE || env_phase == PH_SUSTAIN)
            env_step = '0;
        else
            env_step = env_step + 1'b1;
        prev_level = lvl[LVL_W-1:0];
        r.lvl      = prev_level;
        r.ph       = env_phase;
        return r;
    endfunction

    function automatic bit idle_draw(int cnt);
        if (cnt >= QUIET_FROM && cnt < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 17;
    endfunction

    function automatic logic [CFG_W-1:0] pick_ms();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'($urandom_range(0, 16383));
            2:       return CFG_W'($urandom_range(0, 65535));
            default: return CFG_W'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_sustain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'(FULL_SCALE);
            2:       return CFG_W'($urandom_range(0, 65535));
            default: return CFG_W'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    task automatic send_sample(bit g, bit fixed, logic [LVL_W-1:0] lvl, phase_t ph);
        env_sample_t predicted;
        @(negedge clk);
        while (idle_draw(ticks_sent)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        gate     <= g;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ticks_sent++;
        predicted = next_envelope(g);
        if (fixed) begin
            predicted.lvl = lvl;
            predicted.ph  = ph;
        end
        envelope_due.push_back(predicted);
    endtask

    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (envelope_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_ATTACK:  atk_cfg = data[MS_W-1:0];
            CFG_DECAY:   dec_cfg = data[MS_W-1:0];
            CFG_SUSTAIN: sus_cfg = data[LVL_W-1:0];
            CFG_RELEASE: rel_cfg = data[MS_W-1:0];
            default:     ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_sample();
        env_sample_t want;
        results_seen++;
        if (envelope_due.size() == 0) begin
            mismatches++;
            $display("%0t: result with none due: level %0d phase %0d",
                     $time, level, phase);
        end
        else begin
            want = envelope_due.pop_front();
            if (level !== want.lvl) begin
                mismatches++;
                $display("%0t: level expected %0d got %0d", $time, want.lvl, level);
            end
            if (phase !== want.ph) begin
                mismatches++;
                $display("%0t: phase expected %0d got %0d", $time, want.ph, phase);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("adsr_envelope_generator_core verification failed");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (results_seen >= HOLD_AT && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else begin
                out_stall <= idle_draw(results_seen);
            end
            @(posedge clk);
            if (out_valid && !out_stall)
                check_sample();
        end
    end

    initial
    begin
        int               sent;
        int               run;
        logic [CFG_W-1:0] a_ms, d_ms, s_lvl, r_ms;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        gate         = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ATTACK;
        cfg_data     = '0;
        atk_cfg      = MS_W'(10);
        dec_cfg      = MS_W'(100);
        sus_cfg      = LVL_W'(16384);
        rel_cfg      = MS_W'(200);
        env_phase    = PH_IDLE;
        env_step     = '0;
        rel_start    = '0;
        prev_level   = '0;
        ticks_sent   = 0;
        results_seen = 0;
        mismatches   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                settle_block();
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            end
            else begin
                send_sample(DIRECTED[i].g, DIRECTED[i].fixed, DIRECTED[i].lvl,
                            DIRECTED[i].ph);
            end
        end

        for (int s = 0; s < SETTINGS_RUN; s++) begin
            case (s)
                0:
                begin
                    a_ms  = '0;
                    d_ms  = '0;
                    s_lvl = '0;
                    r_ms  = '0;
                end
                1:
                begin
                    a_ms  = CFG_W'(MAX_MS);
                    d_ms  = CFG_W'(MAX_MS);
                    s_lvl = CFG_W'(FULL_SCALE);
                    r_ms  = CFG_W'(MAX_MS);
                end
                default:
                begin
                    a_ms  = pick_ms();
                    d_ms  = pick_ms();
                    s_lvl = pick_sustain();
                    r_ms  = pick_ms();
                end
            endcase
            settle_block();
            write_reg(CFG_ATTACK, a_ms);
            write_reg(CFG_DECAY, d_ms);
            write_reg(CFG_SUSTAIN, s_lvl);
            write_reg(CFG_RELEASE, r_ms);
            sent = 0;
            while (sent < TICKS_PER_SET) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_sample(1'($urandom_range(0, 1)), 1'b0, '0, PH_IDLE);
                    sent++;
                end
                else begin
                    for (int p = 0; p < 2 && sent < TICKS_PER_SET; p++) begin
                        run = $urandom_range(1, 200);
                        for (int k = 0; k < run && sent < TICKS_PER_SET; k++) begin
                            send_sample(p == 0, 1'b0, '0, PH_IDLE);
                            sent++;
                        end
                    end
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (envelope_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("adsr_envelope_generator_core verification clean");
        else
            $display("adsr_envelope_generator_core verification failed");
        $finish;
    end

endmodule
